// File: rtl/cgmc_pkg.sv
`timescale 1ns / 1ps
package cgmc_pkg;

  localparam int FRAC_W   = 16;
  localparam int FIELD_W  = 16;
  localparam int CFG_W    = 64;
  localparam int TGT_W    = 8;
  localparam int LEN_OUT_W = 8;
  localparam int WRONG_W  = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_ADD    = 2'd1;
  localparam logic [1:0] REG_REMOVE = 2'd2;
  localparam logic [1:0] REG_TARGET = 2'd3;

  localparam logic [1:0] TR_T1R = 2'd0;
  localparam logic [1:0] TR_T1W = 2'd1;
  localparam logic [1:0] TR_T2R = 2'd2;
  localparam logic [1:0] TR_T2W = 2'd3;

  localparam logic [1:0] MV_ADD_RIGHT = 2'd0;
  localparam logic [1:0] MV_ADD_WRONG = 2'd1;
  localparam logic [1:0] MV_REMOVE    = 2'd2;
  localparam logic [1:0] MV_NONE      = 2'd3;

  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
  } cmd_t;

  typedef struct packed {
    logic need_fetch;
  } sts_t;

endpackage

// File: rtl/cgmc_ctrl.sv
`timescale 1ns / 1ps
module cgmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  cgmc_pkg::sts_t     sts,
  output cgmc_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = sts.need_fetch ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/cgmc_datapath.sv
`timescale 1ns / 1ps
module cgmc_datapath #(
  parameter int MAX_LENGTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cgmc_pkg::cmd_t                      cmd,
  output cgmc_pkg::sts_t                      sts,
  input  logic                                in_action,
  input  logic [cgmc_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                cfg_valid,
  input  logic [1:0]                          cfg_index,
  input  logic [cgmc_pkg::CFG_W-1:0]          cfg_data,
  output logic [cgmc_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = (LW > cgmc_pkg::TGT_W) ? LW : cgmc_pkg::TGT_W;
  localparam int FW = cgmc_pkg::FIELD_W;

  logic [cgmc_pkg::CFG_W-1:0]   thresholds;
  logic [cgmc_pkg::CFG_W-1:0]   add_probs;
  logic [cgmc_pkg::CFG_W-1:0]   remove_probs;
  logic [cgmc_pkg::TGT_W-1:0]   target_length;

  logic                         act;
  logic [FW-1:0]                rand_a;
  logic [FW-1:0]                rand_b;
  logic [FW-1:0]                rand_accept;

  logic [LW-1:0]                len;
  logic [cgmc_pkg::WRONG_W-1:0] wrong;
  logic                         top_bit;
  logic                         prev_bit;

  logic                         mem [MAX_LENGTH];
  logic                         rd_bit;
  logic                         rd_zero;

  logic [CW-1:0]                max_w;
  logic [CW-1:0]                tgt_w;
  logic [CW-1:0]                eff_target;
  logic                         active;
  logic [FW-1:0]                r_sel;
  logic [FW-1:0]                thr1;
  logic [FW-1:0]                thr2;
  logic [1:0]                   trans;
  logic [2*cgmc_pkg::CFG_W-1:0] prob_word;
  logic [FW-1:0]                prob;
  logic                         accept;
  logic                         do_push;
  logic                         do_pop;

  logic [LW-1:0]                len_next;
  logic [cgmc_pkg::WRONG_W-1:0] wrong_next;
  logic [1:0]                   move_res;
  logic [1:0]                   trans_res;
  logic                         done_next;
  logic [AW-1:0]                rd_addr;

  always_comb begin
    max_w      = CW'(MAX_LENGTH);
    tgt_w      = CW'(target_length);
    eff_target = (tgt_w < max_w) ? tgt_w : max_w;
    active     = (act == cgmc_pkg::ACT_STEP) && (CW'(len) < eff_target);

    r_sel = prev_bit ? rand_b : rand_a;
    thr1  = prev_bit ? thresholds[2*FW +: FW] : thresholds[0 +: FW];
    thr2  = prev_bit ? thresholds[3*FW +: FW] : thresholds[FW +: FW];

    if (len == LW'(1)) begin
      trans = (rand_a < cgmc_pkg::HALF) ? cgmc_pkg::TR_T1R : cgmc_pkg::TR_T1W;
    end else if (r_sel < thr1) begin
      trans = cgmc_pkg::TR_T1R;
    end else if (r_sel < thr2) begin
      trans = cgmc_pkg::TR_T1W;
    end else begin
      trans = prev_bit ? cgmc_pkg::TR_T2W : cgmc_pkg::TR_T2R;
    end

    prob_word = {remove_probs, add_probs};
    prob      = prob_word[{trans, top_bit} * FW +: FW];
    accept    = rand_accept < prob;

    do_push = active && accept && !trans[1] && (len < LW'(MAX_LENGTH));
    do_pop  = active && accept && trans[1] && (len >= LW'(2));

    len_next   = len;
    wrong_next = wrong;
    move_res   = cgmc_pkg::MV_NONE;
    trans_res  = active ? trans : cgmc_pkg::TR_T1R;
    if (act == cgmc_pkg::ACT_RESTART) begin
      len_next   = LW'(1);
      wrong_next = '0;
    end else if (do_push) begin
      len_next   = len + LW'(1);
      wrong_next = wrong + cgmc_pkg::WRONG_W'(trans[0]);
      move_res   = trans[0] ? cgmc_pkg::MV_ADD_WRONG : cgmc_pkg::MV_ADD_RIGHT;
    end else if (do_pop) begin
      len_next   = len - LW'(1);
      wrong_next = wrong - cgmc_pkg::WRONG_W'(top_bit);
      move_res   = cgmc_pkg::MV_REMOVE;
    end
    done_next = CW'(len_next) >= eff_target;

    rd_addr        = AW'(len - LW'(3));
    sts.need_fetch = do_pop && (len >= LW'(3));
  end

  always_ff @(posedge clk) begin
    if (do_push && cmd.exec) begin
      mem[len[AW-1:0]] <= trans[0];
    end
    rd_bit <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act         <= in_action;
      rand_a      <= in_data[0 +: FW];
      rand_b      <= in_data[FW +: FW];
      rand_accept <= in_data[2*FW +: FW];
    end
    if (cmd.exec) begin
      rd_zero  <= (len == LW'(3));
      out_data <= {4'b0000, done_next, wrong_next,
                   cgmc_pkg::LEN_OUT_W'(len_next), trans_res, move_res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds    <= '0;
      add_probs     <= '0;
      remove_probs  <= '0;
      target_length <= cgmc_pkg::TGT_W'(100);
      len           <= LW'(1);
      wrong         <= '0;
      top_bit       <= 1'b0;
      prev_bit      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cgmc_pkg::REG_THRESH: thresholds    <= cfg_data;
          cgmc_pkg::REG_ADD:    add_probs     <= cfg_data;
          cgmc_pkg::REG_REMOVE: remove_probs  <= cfg_data;
          cgmc_pkg::REG_TARGET: target_length <= cfg_data[cgmc_pkg::TGT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        len   <= len_next;
        wrong <= wrong_next;
        if (act == cgmc_pkg::ACT_RESTART) begin
          top_bit  <= 1'b0;
          prev_bit <= 1'b0;
        end else if (do_push) begin
          top_bit  <= trans[0];
          prev_bit <= top_bit;
        end else if (do_pop) begin
          top_bit  <= prev_bit;
          prev_bit <= 1'b0;
        end
      end
      if (cmd.fetch) begin
        prev_bit <= rd_zero ? 1'b0 : rd_bit;
      end
    end
  end

endmodule

// File: rtl/copolymer_growth_monte_carlo_step.sv
`timescale 1ns / 1ps
// Monte Carlo growth step for a binary copolymer strand of right and wrong monomers.
// Software first loads the choice thresholds, the add and remove acceptance
// fractions and the target length through the configuration channel, while no
// item is in flight. Each item on the slave stream is either a restart (tuser 1)
// or one step carrying three 16-bit random fractions in tdata.
// Every item gives exactly one result item on the master stream: the move made,
// the transition state used, the new strand length, the wrong-monomer count and
// the done flag. Once the target length is reached, steps change nothing.
// The result is written to the output register in the execute step that follows the load.
// An item passes through a load step and an execute step, plus a fetch step when a
// backward move leaves at least two monomers, since the new previous monomer is then
// read from the strand memory through its registered read port. A new item is
// taken when the block is idle; if the result register is still held by a stalled
// receiver, the step waits until it is taken. Reset restores the register defaults
// and a strand of one right monomer; the strand memory needs no clearing pass.
module copolymer_growth_monte_carlo_step #(
  parameter int MAX_LENGTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // rand_a, rand_b, rand_accept
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // move, transition, strand_length, wrong_count, done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cgmc_pkg::cmd_t cmd;
  cgmc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cgmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cgmc_datapath #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (s_tuser),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata)
  );

endmodule

// File: test/tb_copolymer_growth_monte_carlo_step.sv
`timescale 1ns / 1ps
module tb_copolymer_growth_monte_carlo_step;

  localparam int STRAND_DEPTH = 128;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic       done;
    logic [6:0] wrongs;
    logic [7:0] len;
    logic [1:0] trans;
    logic [1:0] move;
  } step_result_t;

  class strand_scoreboard;
    logic [63:0] thresholds = '0;
    logic [63:0] add_fr = '0;
    logic [63:0] remove_fr = '0;
    logic [7:0] target = 8'd100;
    bit strand[STRAND_DEPTH];
    int len = 1;
    int wrongs = 0;
    step_result_t expected_q[$];
    int errors = 0;
    int checked = 0;
    int noted = 0;
    int deepest = 1;
    int moves[4] = '{0, 0, 0, 0};

    function void clear_strand();
      foreach (strand[i]) strand[i] = 1'b0;
      len = 1;
      wrongs = 0;
    endfunction

    function int eff_target();
      return (int'(target) < STRAND_DEPTH) ? int'(target) : STRAND_DEPTH;
    endfunction

    function bit at_target();
      return len >= eff_target();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [15:0] frac(logic [63:0] word, int idx);
      return word[idx*16 +: 16];
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        cgmc_pkg::REG_THRESH: thresholds = data;
        cgmc_pkg::REG_ADD:    add_fr = data;
        cgmc_pkg::REG_REMOVE: remove_fr = data;
        cgmc_pkg::REG_TARGET: target = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic act, logic [47:0] data);
      logic [15:0] ra, rb, racc, r, prob;
      logic [1:0] mv, tr;
      int kind, top_i;
      bit top, prev;
      step_result_t res;
      ra = data[15:0];
      rb = data[31:16];
      racc = data[47:32];
      mv = cgmc_pkg::MV_NONE;
      tr = cgmc_pkg::TR_T1R;
      noted++;
      if (act == cgmc_pkg::ACT_RESTART) begin
        clear_strand();
      end else if (len < eff_target()) begin
        top_i = len - 1;
        top = strand[top_i];
        if (len == 1) begin
          tr = (ra < cgmc_pkg::HALF) ? cgmc_pkg::TR_T1R : cgmc_pkg::TR_T1W;
        end else begin
          prev = strand[len-2];
          r = prev ? rb : ra;
          if (r < frac(thresholds, int'(prev) * 2)) tr = cgmc_pkg::TR_T1R;
          else if (r < frac(thresholds, int'(prev) * 2 + 1)) tr = cgmc_pkg::TR_T1W;
          else tr = prev ? cgmc_pkg::TR_T2W : cgmc_pkg::TR_T2R;
        end
        kind = int'(tr);
        if (kind < 2) prob = frac(add_fr, kind * 2 + int'(top));
        else prob = frac(remove_fr, (kind - 2) * 2 + int'(top));
        if (racc < prob) begin
          if (kind < 2) begin
            if (len < STRAND_DEPTH) begin
              strand[len] = tr[0];
              len++;
              wrongs += int'(tr[0]);
              mv = tr;
            end
          end else if (len >= 2) begin
            if (top) wrongs--;
            strand[top_i] = 1'b0;
            len--;
            mv = cgmc_pkg::MV_REMOVE;
          end
        end
      end
      if (len > deepest) deepest = len;
      res.move = mv;
      res.trans = tr;
      res.len = len[7:0];
      res.wrongs = wrongs[6:0];
      res.done = at_target();
      expected_q = {expected_q, res};
    endfunction

    function void check_result(logic [23:0] data);
      step_result_t got, want;
      got = data[19:0];
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      moves[got.move]++;
      if (got.move !== want.move) begin
        $display("%0t: move expected %0d, got %0d", $time, want.move, got.move);
        errors++;
      end
      if (got.trans !== want.trans) begin
        $display("%0t: transition expected %0d, got %0d", $time, want.trans, got.trans);
        errors++;
      end
      if (got.len !== want.len) begin
        $display("%0t: strand_length expected %0d, got %0d", $time, want.len, got.len);
        errors++;
      end
      if (got.wrongs !== want.wrongs) begin
        $display("%0t: wrong_count expected %0d, got %0d", $time, want.wrongs, got.wrongs);
        errors++;
      end
      if (got.done !== want.done) begin
        $display("%0t: done_res expected %0d, got %0d", $time, want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = cgmc_pkg::REG_THRESH;
  logic [63:0] cfg_data = '0;

  strand_scoreboard sb;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet = 0;

  copolymer_growth_monte_carlo_step DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_copolymer_growth_monte_carlo_step: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic act, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] acc);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    else
      gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {acc, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic load_registers(input logic [63:0] th, input logic [63:0] add_w,
                                input logic [63:0] rem_w, input logic [7:0] tgt);
    logic [1:0] idx[4];
    logic [63:0] vals[4];
    idx = '{cgmc_pkg::REG_THRESH, cgmc_pkg::REG_ADD, cgmc_pkg::REG_REMOVE,
            cgmc_pkg::REG_TARGET};
    vals = '{th, add_w, rem_w, {56'd0, tgt}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // The block may still be finishing a removal after its result has left,
  // so the task idles after the last result before the registers are touched.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [63:0] th, add_w, rem_w;
    logic [15:0] r1, r2, w1, w2;
    logic [7:0] tgt;
    logic act;
    bit grow;
    int n;
    sb = new;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: nothing is ever accepted, the half split decides the state.
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'hFFFF, 16'hFFFF, 16'h0000);
    drain();

    load_registers(64'h9000_3000_A000_4000, '1, '1, 8'd8);
    send_item(cgmc_pkg::ACT_STEP, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h8000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'hFFFF, 16'hFFFE);
    send_item(cgmc_pkg::ACT_STEP, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h5000, 16'h5000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h5000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_STEP, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(cgmc_pkg::ACT_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(cgmc_pkg::ACT_RESTART, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Targets of one and zero count as reached straight away.
    load_registers(64'h9000_3000_A000_4000, '1, '1, 8'd1);
    send_item(cgmc_pkg::ACT_STEP, 16'h0000, 16'h0000, 16'h0000);
    send_item(cgmc_pkg::ACT_RESTART, 16'h1234, 16'h5678, 16'h9ABC);
    drain();
    load_registers(64'h9000_3000_A000_4000, '1, '1, 8'd0);
    send_item(cgmc_pkg::ACT_STEP, 16'hFFFF, 16'hFFFF, 16'h0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: tgt = 8'd128;
        1: tgt = 8'd2;
        2: tgt = 8'd255;
        default: tgt = 8'($urandom_range(2, 128));
      endcase
      grow = (ph % 2 == 0) || ($urandom_range(0, 1) == 1);
      n = (ph == 0 || ph == 2) ? 180 : 65;
      if (grow) begin
        r1 = 16'($urandom_range(16'h4000, 16'hC000));
        r2 = 16'($urandom_range(16'hE000, 16'hFFFF));
        w1 = 16'($urandom_range(16'h4000, 16'hC000));
        w2 = 16'($urandom_range(16'hE000, 16'hFFFF));
        th = {w2, w1, r2, r1};
        for (int k = 0; k < 4; k++) begin
          add_w[k*16 +: 16] = 16'($urandom_range(16'hC000, 16'hFFFF));
          rem_w[k*16 +: 16] = 16'($urandom_range(0, 16'h4000));
        end
      end else begin
        th = {$urandom, $urandom};
        add_w = {$urandom, $urandom};
        rem_w = {$urandom, $urandom};
      end
      load_registers(th, add_w, rem_w, tgt);
      send_item(cgmc_pkg::ACT_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < n; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (sb.at_target() ? ($urandom_range(0, 9) < 7)
                           : ($urandom_range(0, 99) < (grow ? 1 : 5)))
          act = cgmc_pkg::ACT_RESTART;
        else
          act = cgmc_pkg::ACT_STEP;
        send_item(act, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      drain();
    end

    calm = 1'b1;
    repeat (8) @(posedge clk);
    $display("Sent %0d items and checked %0d results under several register settings.",
             sb.noted, sb.checked);
    $display("Moves seen: %0d right adds, %0d wrong adds, %0d removals, %0d idle;",
             sb.moves[cgmc_pkg::MV_ADD_RIGHT], sb.moves[cgmc_pkg::MV_ADD_WRONG],
             sb.moves[cgmc_pkg::MV_REMOVE], sb.moves[cgmc_pkg::MV_NONE]);
    $display("Longest strand reached: %0d.", sb.deepest);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_copolymer_growth_monte_carlo_step: clean");
    end else begin
      $display("tb_copolymer_growth_monte_carlo_step: errors");
    end
    $finish;
  end

endmodule
